// ===== rtl/tvl_pkg.sv =====
// Shared types and constants for the twist velocity limiter.
// Holds payload structs, register indexes, widths and the pipeline geometry.
// No dependencies.
package tvl_pkg;

  localparam int VAL_W        = 16;  // signed Q4.12 component
  localparam int LIM_W        = 15;  // unsigned Q3.12 limit register
  localparam int MAG_W        = 16;  // |component|, up to 32768
  localparam int SQ_W         = 32;  // |component|^2
  localparam int NUM_W        = 31;  // |component| * linear limit
  localparam int LSQ_W        = 30;  // linear limit squared
  localparam int SUM_W        = 32;  // sum of three squares
  localparam int PROD_W       = 62;  // q^2 * S and (|c| * L)^2
  localparam int QS_W         = 47;  // q * S
  localparam int NB           = 15;  // result bits found by each lane
  localparam int NLANE        = 3;
  localparam int FRONT_STAGES = 3;
  localparam int NSTAGE       = FRONT_STAGES + NB + 1;
  localparam int IDX_W        = 1;

  localparam logic [LIM_W-1:0] LINEAR_LIMIT_RESET  = 15'd4096;  // 1.0
  localparam logic [LIM_W-1:0] ANGULAR_LIMIT_RESET = 15'd2048;  // 0.5

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LINEAR_LIMIT  = 1'b0,
    REG_ANGULAR_LIMIT = 1'b1
  } reg_index_t;

  typedef struct packed {
    val_t lin_x;
    val_t lin_y;
    val_t lin_z;
    val_t ang_x;
    val_t ang_y;
    val_t ang_z;
  } twist_t;

  typedef struct packed {
    val_t cmd_lin_x;
    val_t cmd_lin_y;
    val_t cmd_lin_z;
    val_t cmd_ang_x;
    val_t cmd_ang_y;
    val_t cmd_ang_z;
    logic linear_scaled;
    logic yaw_clamped;
  } result_t;

  // Per-item fields that ride alongside the lanes
  typedef struct packed {
    val_t ang_x;
    val_t ang_y;
    val_t ang_z;
    logic linear_scaled;
    logic yaw_clamped;
  } side_t;

endpackage

// ===== rtl/tvl_stream_if.sv =====
// Valid/ready channel carrying one item of any packed payload type.
// Depends on nothing; payload types come from tvl_pkg at instantiation.
interface tvl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/tvl_front.sv =====
// Front stages: magnitudes, products, sum of squares, targets and yaw clamp.
// Three registered stages, each advanced by its own enable. Uses tvl_pkg.
module tvl_front (
  input  logic                                  clk,
  input  logic [tvl_pkg::FRONT_STAGES-1:0]      en,
  input  tvl_pkg::twist_t                       twist,
  input  logic [tvl_pkg::LIM_W-1:0]             linear_limit,
  input  logic [tvl_pkg::LIM_W-1:0]             angular_limit,
  output logic [tvl_pkg::SUM_W-1:0]             sum_sq,
  output logic [tvl_pkg::PROD_W-1:0]            target [tvl_pkg::NLANE],
  output tvl_pkg::val_t                         orig   [tvl_pkg::NLANE],
  output tvl_pkg::side_t                        side
);

  localparam int NLANE  = tvl_pkg::NLANE;
  localparam int SQ_W   = tvl_pkg::SQ_W;
  localparam int NUM_W  = tvl_pkg::NUM_W;
  localparam int LSQ_W  = tvl_pkg::LSQ_W;
  localparam int PROD_W = tvl_pkg::PROD_W;

  tvl_pkg::val_t                  lin_in    [NLANE];
  logic [tvl_pkg::MAG_W-1:0]      mag_next  [NLANE];
  logic [tvl_pkg::MAG_W-1:0]      az_mag;
  tvl_pkg::val_t                  al_pos;
  tvl_pkg::side_t                 side_next;

  logic [tvl_pkg::MAG_W-1:0]      mag_a     [NLANE];
  tvl_pkg::val_t                  orig_a    [NLANE];
  logic [tvl_pkg::LIM_W-1:0]      lim_a;
  tvl_pkg::side_t                 side_a;

  logic [tvl_pkg::SQ_W-1:0]       sq_b      [NLANE];
  logic [tvl_pkg::NUM_W-1:0]      num_b     [NLANE];
  logic [tvl_pkg::LSQ_W-1:0]      lim2_b;
  tvl_pkg::val_t                  orig_b    [NLANE];
  tvl_pkg::side_t                 side_b;

  logic [tvl_pkg::SUM_W-1:0]      sum_next;
  tvl_pkg::side_t                 side_out_next;

  // Stage A: magnitudes and the yaw clamp
  always_comb begin
    lin_in[0] = twist.lin_x;
    lin_in[1] = twist.lin_y;
    lin_in[2] = twist.lin_z;
    for (int i = 0; i < NLANE; i++) begin
      mag_next[i] = lin_in[i][tvl_pkg::VAL_W-1] ? -lin_in[i] : lin_in[i];
    end
    az_mag = twist.ang_z[tvl_pkg::VAL_W-1] ? -twist.ang_z : twist.ang_z;
    al_pos = {1'b0, angular_limit};
    side_next.ang_x         = twist.ang_x;
    side_next.ang_y         = twist.ang_y;
    side_next.yaw_clamped   = az_mag > {1'b0, angular_limit};
    side_next.linear_scaled = 1'b0;
    if (side_next.yaw_clamped) begin
      side_next.ang_z = twist.ang_z[tvl_pkg::VAL_W-1] ? -al_pos : al_pos;
    end else begin
      side_next.ang_z = twist.ang_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_a  <= mag_next;
      orig_a <= lin_in;
      lim_a  <= linear_limit;
      side_a <= side_next;
    end
  end

  // Stage B: squares and numerators
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NLANE; i++) begin
        sq_b[i]  <= SQ_W'(mag_a[i]) * SQ_W'(mag_a[i]);
        num_b[i] <= NUM_W'(mag_a[i]) * NUM_W'(lim_a);
      end
      lim2_b <= LSQ_W'(lim_a) * LSQ_W'(lim_a);
      orig_b <= orig_a;
      side_b <= side_a;
    end
  end

  // Stage C: norm squared against limit squared, squared numerators
  assign sum_next = sq_b[0] + sq_b[1] + sq_b[2];

  always_comb begin
    side_out_next               = side_b;
    side_out_next.linear_scaled = sum_next > {2'b00, lim2_b};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum_sq <= sum_next;
      for (int i = 0; i < NLANE; i++) begin
        // numerator is 31 bits wide; widen to hold its square
        target[i] <= PROD_W'(num_b[i]) * PROD_W'(num_b[i]);
      end
      orig <= orig_b;
      side <= side_out_next;
    end
  end

endmodule

// ===== rtl/tvl_lane.sv =====
// One lane: restoring bit search for the largest q with q^2 * S <= (|c| * L)^2.
// One result bit per registered stage, squares kept incrementally. Uses tvl_pkg.
module tvl_lane (
  input  logic                             clk,
  input  logic [tvl_pkg::NB-1:0]           en,
  input  logic [tvl_pkg::SUM_W-1:0]        sum_sq,
  input  logic [tvl_pkg::PROD_W-1:0]       target,
  input  tvl_pkg::val_t                    orig,
  output logic [tvl_pkg::NB-1:0]           mag_q,
  output tvl_pkg::val_t                    orig_out
);

  localparam int NB     = tvl_pkg::NB;
  localparam int PROD_W = tvl_pkg::PROD_W;
  localparam int QS_W   = tvl_pkg::QS_W;
  localparam int SUM_W  = tvl_pkg::SUM_W;

  // Stage j registers; the last stage keeps only q and the original value
  logic [PROD_W-1:0]  p_r   [NB-1];
  logic [QS_W-1:0]    qs_r  [NB-1];
  logic [SUM_W-1:0]   s_r   [NB-1];
  logic [PROD_W-1:0]  tg_r  [NB-1];
  logic [NB-1:0]      q_r   [NB];
  tvl_pkg::val_t      org_r [NB];

  for (genvar j = 0; j < NB; j++) begin : g_stage
    localparam int B = NB - 1 - j;

    logic [PROD_W-1:0] p_in;
    logic [QS_W-1:0]   qs_in;
    logic [SUM_W-1:0]  s_in;
    logic [PROD_W-1:0] tg_in;
    logic [NB-1:0]     q_in;
    tvl_pkg::val_t     org_in;
    logic [PROD_W-1:0] cand;
    logic              take;

    if (j == 0) begin : g_head
      assign p_in   = '0;
      assign qs_in  = '0;
      assign s_in   = sum_sq;
      assign tg_in  = target;
      assign q_in   = '0;
      assign org_in = orig;
    end else begin : g_body
      assign p_in   = p_r[j-1];
      assign qs_in  = qs_r[j-1];
      assign s_in   = s_r[j-1];
      assign tg_in  = tg_r[j-1];
      assign q_in   = q_r[j-1];
      assign org_in = org_r[j-1];
    end

    // (q + 2^B)^2 S = q^2 S + 2^(B+1) q S + 2^(2B) S
    assign cand = p_in
                + ({{(PROD_W-QS_W){1'b0}}, qs_in} << (B + 1))
                + ({{(PROD_W-SUM_W){1'b0}}, s_in} << (2 * B));
    assign take = cand <= tg_in;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        q_r[j]   <= q_in | ({{(NB-1){1'b0}}, take} << B);
        org_r[j] <= org_in;
      end
    end

    if (j < NB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          p_r[j]  <= take ? cand : p_in;
          qs_r[j] <= take ? qs_in + ({{(QS_W-SUM_W){1'b0}}, s_in} << B) : qs_in;
          s_r[j]  <= s_in;
          tg_r[j] <= tg_in;
        end
      end
    end
  end

  assign mag_q    = q_r[NB-1];
  assign orig_out = org_r[NB-1];

endmodule

// ===== rtl/twist_velocity_limiter_unit.sv =====
// Pipeline: 3 front stages, 15 search stages in each of three lanes and 1 output
// register lie between the accepting edge and the result on cmd.
// Throughput: one item per cycle while cmd does not stall; every stage holds one item and the three
// lanes find one quotient bit per stage in step.
// Reset (synchronous, rst high): empty all stages, limits to 1.0 and 0.5.
// Depends on tvl_pkg, tvl_stream_if, tvl_front and tvl_lane.
module twist_velocity_limiter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tvl_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tvl_pkg::LIM_W-1:0]     cfg_data,
  tvl_stream_if.sink                    twist,
  tvl_stream_if.source                  cmd
);

  localparam int NS    = tvl_pkg::NSTAGE;
  localparam int FS    = tvl_pkg::FRONT_STAGES;
  localparam int NB    = tvl_pkg::NB;
  localparam int NLANE = tvl_pkg::NLANE;

  // Configuration registers
  logic [tvl_pkg::LIM_W-1:0] linear_limit;
  logic [tvl_pkg::LIM_W-1:0] angular_limit;

  // Pipeline occupancy and per-stage advance
  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  // Front to lanes
  logic [tvl_pkg::SUM_W-1:0]  sum_sq;
  logic [tvl_pkg::PROD_W-1:0] target [NLANE];
  tvl_pkg::val_t              orig   [NLANE];
  tvl_pkg::side_t             side_f;

  // Lane results
  logic [NB-1:0]              mag_q  [NLANE];
  tvl_pkg::val_t              orig_l [NLANE];

  // Fields that travel beside the lanes
  tvl_pkg::side_t             side_r [NB];

  tvl_pkg::val_t              lin_res [NLANE];
  tvl_pkg::result_t           result_next;

  // Write a limit; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_limit  <= tvl_pkg::LINEAR_LIMIT_RESET;
      angular_limit <= tvl_pkg::ANGULAR_LIMIT_RESET;
    end else if (cfg_we) begin
      case (tvl_pkg::reg_index_t'(cfg_index))
        tvl_pkg::REG_LINEAR_LIMIT:  linear_limit  <= cfg_data;
        tvl_pkg::REG_ANGULAR_LIMIT: angular_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it or any stage after it up to the output register
  // is empty, or when the output is being taken.
  // Bubbles therefore collapse and a new item enters while a result waits.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      adv[k] = cmd.ready || !(&(v | NS'((1 << k) - 1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= twist.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign twist.ready = adv[0];
  assign cmd.valid   = v[NS-1];

  // Front: magnitudes, norm squared test, targets, yaw clamp
  tvl_front u_front (
    .clk           (clk),
    .en            (adv[FS-1:0]),
    .twist         (twist.payload),
    .linear_limit  (linear_limit),
    .angular_limit (angular_limit),
    .sum_sq        (sum_sq),
    .target        (target),
    .orig          (orig),
    .side          (side_f)
  );

  // One search lane per linear component
  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    tvl_lane u_lane (
      .clk      (clk),
      .en       (adv[FS+NB-1:FS]),
      .sum_sq   (sum_sq),
      .target   (target[i]),
      .orig     (orig[i]),
      .mag_q    (mag_q[i]),
      .orig_out (orig_l[i])
    );
  end

  // Carry the angular fields and flags in step with the lanes
  always_ff @(posedge clk) begin
    if (adv[FS]) begin
      side_r[0] <= side_f;
    end
    for (int j = 1; j < NB; j++) begin
      if (adv[FS+j]) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // Merge: restore the sign on each scaled magnitude, or keep the original
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      if (side_r[NB-1].linear_scaled) begin
        lin_res[i] = orig_l[i][tvl_pkg::VAL_W-1] ? -tvl_pkg::val_t'({1'b0, mag_q[i]})
                                                 : tvl_pkg::val_t'({1'b0, mag_q[i]});
      end else begin
        lin_res[i] = orig_l[i];
      end
    end
    result_next.cmd_lin_x     = lin_res[0];
    result_next.cmd_lin_y     = lin_res[1];
    result_next.cmd_lin_z     = lin_res[2];
    result_next.cmd_ang_x     = side_r[NB-1].ang_x;
    result_next.cmd_ang_y     = side_r[NB-1].ang_y;
    result_next.cmd_ang_z     = side_r[NB-1].ang_z;
    result_next.linear_scaled = side_r[NB-1].linear_scaled;
    result_next.yaw_clamped   = side_r[NB-1].yaw_clamped;
  end

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      cmd.payload <= result_next;
    end
  end

  // A result only appears when the stage before the output held an item
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd.valid) |-> $past(v[NS-2]))
    else $error("output valid rose without an item in the last lane stage");

  // Input is refused only when every stage is occupied
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    !twist.ready |-> (&v))
    else $error("input refused while the pipeline has a free stage");

  // A scaled linear component never reaches the most negative code
  a_scaled_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.payload.linear_scaled) |->
      (cmd.payload.cmd_lin_x != 16'sh8000) && (cmd.payload.cmd_lin_y != 16'sh8000) &&
      (cmd.payload.cmd_lin_z != 16'sh8000))
    else $error("scaled linear component out of range");

  // A clamped yaw rate never reaches the most negative code
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.payload.yaw_clamped) |-> (cmd.payload.cmd_ang_z != 16'sh8000))
    else $error("clamped yaw rate out of range");

endmodule
